>>> rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII core.
// No dependencies; imported by sitda_cell and signed_int_to_decimal_ascii_core.
package sitda_pkg;

	localparam int MAG_W      = 32;               // magnitude width
	localparam int NUM_DIGITS = 10;               // decimal digits of 2**32 - 1
	localparam int BIT_CNT_W  = $clog2(MAG_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(MAG_W - 1);
	localparam logic [DIG_CNT_W-1:0] DIG_CNT_FULL = DIG_CNT_W'(NUM_DIGITS);
	localparam logic [DIG_CNT_W-1:0] DIG_CNT_ONE  = DIG_CNT_W'(1);

	typedef logic [3:0] bcd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// Per-cycle command to every digit cell.
	typedef struct packed {
		logic clear;      // zero the digit
		logic bit_shift;  // double-dabble step: adjust, shift one bit up the row
		logic dig_shift;  // move whole digits one cell toward the top
	} cell_ctrl_t;

endpackage

>>> rtl/sitda_cell.sv
// One BCD digit cell of the double-dabble row.
// Depends on sitda_pkg (bcd_t, cell_ctrl_t).
module sitda_cell
	import sitda_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       bit_in,   // carry from the lower cell (or the binary word)
	input  bcd_t       dig_in,   // digit of the lower cell
	output logic       bit_out,  // carry into the upper cell
	output bcd_t       digit
);

	bcd_t digit_q;
	bcd_t adj;

	// add 3 before the shift when the digit would overflow past 9
	assign adj     = (digit_q >= 4'd5) ? bcd_t'(digit_q + 4'd3) : digit_q;
	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.bit_shift) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.dig_shift) begin
			digit_q <= dig_in;
		end
	end

endmodule

>>> rtl/signed_int_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Depends on sitda_pkg and sitda_cell.
//
// Takes one two's complement 32-bit value per transaction and returns its
// decimal text one character per output transaction, most significant digit
// first, no leading zeros, with a leading '-' for negative values and a single
// '0' for zero; last marks the final character. The most negative value comes
// out as "-2147483648". One value is in work at a time: item_stall is high from
// acceptance until the final character has been placed in the output register.
// Steps per value: accept, then double-dabble conversion (one magnitude bit
// per cycle through a row of ten BCD digit cells), then drop each leading
// zero (up to 9) and leave that step, then the sign if negative and the
// digits (1 to 10) as the output register can take them. Dropped zeros and
// digits always add up to ten. The next value can be accepted once the last
// character is in the output register. The bit-serial conversion row takes
// most of the time. The output register lets the next value be accepted
// while the last character still waits. Nothing is kept between values.
module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              item_valid,
	output logic              item_stall,
	input  logic signed [31:0] value,
	// output channel
	output logic              text_valid,
	input  logic              text_stall,
	output logic [7:0]        character,
	output logic              last
);

	state_t state_q, state_d;

	logic [MAG_W-1:0]     mag_q;      // magnitude, shifted out MSB first
	logic                 neg_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;  // conversion steps left minus one
	logic [DIG_CNT_W-1:0] dig_left_q; // digits still in the row to emit

	logic       out_valid_q;
	logic [7:0] char_q;
	logic       last_q;

	cell_ctrl_t ctrl;
	logic       accept;
	logic       out_free;
	logic       out_load;
	logic [7:0] out_char;
	logic       out_last;

	logic [NUM_DIGITS-1:0] carry;    // carry[i] feeds cell i
	bcd_t                  digits [NUM_DIGITS];
	bcd_t                  top_digit;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !text_stall;
	assign top_digit  = digits[NUM_DIGITS-1];

	// ---------------- digit cell row ----------------
	assign carry[0] = mag_q[MAG_W-1];

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_bottom
			sitda_cell u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.bit_in  (carry[0]),
				.dig_in  (bcd_t'(0)),
				.bit_out (carry[1]),
				.digit   (digits[0])
			);
		end else if (i == NUM_DIGITS - 1) begin : g_top
			// a 32-bit magnitude never carries out of the top digit
			sitda_cell u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.bit_in  (carry[i]),
				.dig_in  (digits[i-1]),
				.bit_out (),
				.digit   (digits[i])
			);
		end else begin : g_mid
			sitda_cell u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.bit_in  (carry[i]),
				.dig_in  (digits[i-1]),
				.bit_out (carry[i+1]),
				.digit   (digits[i])
			);
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		out_load  = 1'b0;
		out_char  = ASCII_ZERO;
		out_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.clear = 1'b1;
					state_d    = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.bit_shift = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, always keep the units digit
				if (top_digit == '0 && dig_left_q != DIG_CNT_ONE) begin
					ctrl.dig_shift = 1'b1;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_char = ASCII_MINUS;
					state_d  = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_char = ASCII_ZERO | {4'd0, top_digit};
					if (dig_left_q == DIG_CNT_ONE) begin
						out_last = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						ctrl.dig_shift = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// magnitude, sign and counters
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q      <= value[31];
			mag_q      <= value[31] ? MAG_W'(-value) : MAG_W'(value);
			bit_cnt_q  <= BIT_CNT_LAST;
			dig_left_q <= DIG_CNT_FULL;
		end else begin
			if (ctrl.bit_shift) begin
				mag_q     <= {mag_q[MAG_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			if (ctrl.dig_shift) begin
				dig_left_q <= dig_left_q - 1'b1;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign text_valid = out_valid_q;
	assign character  = char_q;
	assign last       = last_q;

endmodule

>>> tb/signed_int_to_decimal_ascii_core_tb.sv
// Testbench for signed_int_to_decimal_ascii_core: drives signed 32-bit values and
// checks every ASCII character and last flag against its own decimal expansion.
// Depends on sitda_pkg and the core RTL; needs nothing else.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_core_tb
	import sitda_pkg::*;
();

	// One expected output character with its end-of-text flag.
	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} text_char_t;

	// Expands each accepted value into its decimal text and checks the
	// characters as they leave the core, oldest first.
	class decimal_text_tracker;
		text_char_t pending_chars[$];
		int values_seen;
		int chars_seen;
		int negatives;
		int zeros;
		int mismatches;

		function void note_value(logic [31:0] raw);
			logic [31:0] mag;
			logic [3:0]  digs [0:9];
			int          nd;
			values_seen++;
			// unsigned negation gives 2147483648 for the most negative value
			mag = raw[31] ? (32'd0 - raw) : raw;
			if (raw[31])
				negatives++;
			if (raw == 32'd0)
				zeros++;
			nd = 0;
			do begin
				digs[nd] = 4'(mag % 32'd10);
				mag = mag / 32'd10;
				nd++;
			end while (mag != 32'd0);
			if (raw[31])
				pending_chars.push_back('{code: ASCII_MINUS, fin: 1'b0});
			for (int i = nd - 1; i >= 0; i--)
				pending_chars.push_back('{code: ASCII_ZERO + 8'(digs[i]), fin: (i == 0)});
		endfunction

		function void check_char(logic [7:0] code, logic fin);
			text_char_t want;
			chars_seen++;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: character %0d (last=%0b) arrived with nothing expected",
						$realtime, code, fin);
				return;
			end
			want = pending_chars.pop_front();
			if (want.code !== code || want.fin !== fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: expected character %0d last=%0b, got %0d last=%0b",
						$realtime, want.code, want.fin, code, fin);
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic signed [31:0] value      = '0;
	logic               text_valid;
	logic               text_stall = 1'b0;
	logic [7:0]         character;
	logic               last;

	decimal_text_tracker tracker = new;

	// quiet: no idling on either side; hold_out: request a long output hold-off
	bit quiet    = 1'b0;
	bit hold_out = 1'b0;

	// Hand-picked values: zero, single digits, powers of ten and their
	// neighbors, both ends of the range, and alternating bit patterns so every
	// input bit sees both levels early on.
	localparam int NUM_CORNERS = 22;
	localparam logic [31:0] CORNERS [NUM_CORNERS] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
		-32'd101, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
		32'd999999999, -32'd999999999, -32'd1000000000, 32'd1234567890,
		-32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'd5
	};

	signed_int_to_decimal_ascii_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.character  (character),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both channels are sampled at the rising edge; inputs change there only
	// through nonblocking assignments, so these reads see pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				tracker.note_value(value);
			if (text_valid && !text_stall)
				tracker.check_char(character, last);
		end
	end

	// Output side back pressure. Short random stalls unless quiet; on request,
	// one long hold-off so the core fills its output register and blocks its
	// input while the sender keeps offering.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				text_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_out = 1'b0;
				text_stall <= 1'b0;
			end else if (!quiet && arst_n && $urandom_range(0, 4) == 0) begin
				text_stall <= 1'b1;
				n = $urandom_range(1, 4);
				repeat (n) @(posedge clk);
				text_stall <= 1'b0;
			end else begin
				text_stall <= 1'b0;
			end
		end
	end

	// Offers one value and returns at the edge where the transaction happens.
	// Valid stays high straight into the next value unless an idle burst falls
	// in between.
	task automatic send_value(logic [31:0] v);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		value      <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Random values with a spread of lengths: full 32-bit words, short numbers,
	// powers of ten +/- 1 (digit count boundaries), and shifted words for
	// everything in between. Sign is chosen separately, except for full words.
	function automatic logic [31:0] pick_value();
		logic [31:0] mag;
		int          kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: return $urandom;
			2: mag = $urandom_range(0, 99);
			3: begin
				mag = 32'd1;
				repeat ($urandom_range(0, 9)) mag = mag * 32'd10;
				mag = mag + 32'($urandom_range(0, 2)) - 32'd1;
			end
			default: mag = $urandom >> $urandom_range(0, 31);
		endcase
		return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed values first.
		foreach (CORNERS[i])
			send_value(CORNERS[i]);

		// Random values; one long output hold-off part way through, then the
		// last stretch with no idling on either side.
		for (int i = 0; i < 158; i++) begin
			if (i == 60)
				hold_out = 1'b1;
			if (i == 130)
				quiet = 1'b1;
			send_value(pick_value());
		end
		item_valid <= 1'b0;

		// Drain: every expected character must arrive, then a margin of about
		// one conversion to catch anything extra.
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("Converted %0d values (%0d negative, %0d zero) into %0d characters",
			tracker.values_seen, tracker.negatives, tracker.zeros, tracker.chars_seen);
		$display("Mismatched or unexpected characters: %0d", tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("[signed_int_to_decimal_ascii_core] OK");
		else
			$display("[signed_int_to_decimal_ascii_core] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (about 180 values with
	// worst-case stalls, plus the long hold-off).
	initial begin
		#(2_000_000);
		$display("Timed out with %0d characters still expected", tracker.pending());
		$display("[signed_int_to_decimal_ascii_core] ERROR");
		$finish;
	end

endmodule
